### design/sensor_frame_checker_macros.svh
// Assertion macros used by the sensor frame checker port assertions (sfc_checker).
`ifndef SENSOR_FRAME_CHECKER_MACROS_SVH
`define SENSOR_FRAME_CHECKER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfc assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent, also during reset.
`define SFC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sfc assertion failed");

`endif

### design/sfc_pkg.sv
// Package with types, constants and the CRC function of the sensor frame checker.
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

   // Frame layout constants.
   localparam int HEADER_BYTES_DEF = 8;
   localparam int CRC_BYTES        = 2;
   localparam int COUNT_W          = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Stream widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USED_W = 107;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 1'b1;

   // Frame status codes.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_CRC_BAD   = 3'd1,
      STATUS_SHORT     = 3'd2,
      STATUS_BAD_START = 3'd3,
      STATUS_LEN_BAD   = 3'd4
   } status_type;

   // One result word.
   typedef struct packed {
      logic        is_payload;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic        frame_done;
      status_type  status;
      logic [7:0]  version;
      logic [7:0]  msg_type;
      logic [15:0] sequence_res;
      logic [15:0] length_res;
      logic [15:0] crc_received;
      logic [15:0] crc_computed;
   } result_type;

   // Start byte values from the configuration registers.
   typedef struct packed {
      logic [7:0] start_first;
      logic [7:0] start_second;
   } start_cfg_type;

   // CRC-16/MODBUS update over one byte, reflected form.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### design/sfc_core.sv
// Frame parser: position tracking, header capture, CRC, status; a byte per accept cycle.
`timescale 1ns / 1ps
`default_nettype none
module sfc_core #(
   parameter int HEADER_BYTES = sfc_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_accept,
   input  wire logic [7:0]            frame_byte,
   input  wire logic                  final_byte,
   input  wire sfc_pkg::start_cfg_type start_cfg,
   output      sfc_pkg::result_type    result
);
   import sfc_pkg::*;

   localparam logic [COUNT_W-1:0] HDR = COUNT_W'(HEADER_BYTES);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        length_ff, length_in;
   logic [7:0]         version_ff, version_in;
   logic [7:0]         type_ff, type_in;
   logic [15:0]        seq_ff, seq_in;
   logic [15:0]        crc_field_ff, crc_field_in;
   logic               start_bad_ff, start_bad_in;

   logic [COUNT_W-1:0] pay_end;
   logic [COUNT_W-1:0] n_bytes;
   logic               in_payload;
   status_type         status;

   // Per-byte update of the frame state; everything is derived from the current position.
   always_comb begin
      pay_end      = HDR + {1'b0, length_ff};
      version_in   = version_ff;
      type_in      = type_ff;
      seq_in       = seq_ff;
      length_in    = length_ff;
      start_bad_in = start_bad_ff;
      crc_in       = crc_ff;
      crc_field_in = crc_field_ff;

      case (count_ff)
         COUNT_W'(0): if (frame_byte != start_cfg.start_first) start_bad_in = 1'b1;
         COUNT_W'(1): if (frame_byte != start_cfg.start_second) start_bad_in = 1'b1;
         COUNT_W'(2): version_in = frame_byte;
         COUNT_W'(3): type_in = frame_byte;
         COUNT_W'(4): seq_in = {seq_ff[15:8], frame_byte};
         COUNT_W'(5): seq_in = {frame_byte, seq_ff[7:0]};
         COUNT_W'(6): length_in = {length_ff[15:8], frame_byte};
         COUNT_W'(7): length_in = {frame_byte, length_ff[7:0]};
         default: ;
      endcase

      // The CRC covers the header after the start bytes and the payload.
      if (count_ff >= COUNT_W'(2) && (count_ff < HDR || count_ff < pay_end)) begin
         crc_in = crc16_byte(crc_ff, frame_byte);
      end

      in_payload = (count_ff >= HDR) && (count_ff < pay_end);

      // Trailing CRC bytes, little-endian.
      if (count_ff >= HDR) begin
         if (count_ff == pay_end) begin
            crc_field_in = {crc_field_ff[15:8], frame_byte};
         end else if (count_ff == pay_end + COUNT_W'(1)) begin
            crc_field_in = {frame_byte, crc_field_ff[7:0]};
         end
      end

      // The byte count saturates on overlong frames.
      n_bytes = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

      // Checks in priority order.
      if (n_bytes < HDR + COUNT_W'(CRC_BYTES)) begin
         status = STATUS_SHORT;
      end else if (start_bad_in) begin
         status = STATUS_BAD_START;
      end else if (n_bytes != pay_end + COUNT_W'(CRC_BYTES)) begin
         status = STATUS_LEN_BAD;
      end else if (crc_field_in != crc_in) begin
         status = STATUS_CRC_BAD;
      end else begin
         status = STATUS_OK;
      end

      count_in = n_bytes;
   end

   // Result word for the byte on the input; summary fields only on the final byte.
   always_comb begin
      result = '0;
      if (in_payload) begin
         result.is_payload    = 1'b1;
         result.payload_byte  = frame_byte;
         result.payload_index = 16'(count_ff - HDR);
      end
      if (final_byte) begin
         result.frame_done     = 1'b1;
         result.status         = status;
         result.version        = version_in;
         result.msg_type       = type_in;
         result.sequence_res   = seq_in;
         result.length_res     = length_in;
         result.crc_received   = crc_field_in;
         result.crc_computed   = crc_in;
      end
   end

   // Frame state; the final byte returns it to the start of a frame.
   always_ff @(posedge clock) begin
      if (reset || (byte_accept && final_byte)) begin
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         length_ff    <= '0;
         version_ff   <= '0;
         type_ff      <= '0;
         seq_ff       <= '0;
         crc_field_ff <= '0;
         start_bad_ff <= 1'b0;
      end else if (byte_accept) begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         length_ff    <= length_in;
         version_ff   <= version_in;
         type_ff      <= type_in;
         seq_ff       <= seq_in;
         crc_field_ff <= crc_field_in;
         start_bad_ff <= start_bad_in;
      end
   end

endmodule
`default_nettype wire

### design/sensor_frame_checker.sv
// Top level of the sensor frame checker: stream ports, start byte registers, result buffer.
//
// The req_ channel takes one frame byte per word in req_tdata[7:0]; req_tlast marks
// the last byte of a frame. The rsp_ channel gives exactly one result word per input
// word, in order. rsp_tuser flags a payload byte; rsp_tlast flags the final byte,
// on which the summary fields (status, header fields, both CRCs) are valid and the
// checker returns to the start of a frame. Fields that do not apply read as zero.
// The csr_ channel writes the two expected start bytes (index 0 and 1); it is always
// ready and should be used only while no frame is in flight.
// An accepted input word's result is registered in the output register, or in the skid
// register if the output register holds a stalled result. Throughput is one word per
// cycle while req_tready is high. A two-entry result buffer (output register plus skid
// register) keeps req_tready independent of rsp_tready; when the receiver stalls, up to
// two results are held and req_tready drops only once both are full.
// Reset is synchronous: it empties the buffer, clears the frame state and sets both
// start byte registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module sensor_frame_checker #(
   parameter int HEADER_BYTES = sfc_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata: frame_byte[7:0]
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [sfc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tlast,
   // rsp_tdata: payload_byte[7:0], payload_index[23:8], status[26:24], version[34:27],
   // msg_type[42:35], sequence_res[58:43], length_res[74:59],
   // crc_received[90:75], crc_computed[106:91], zero fill [111:107]
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [sfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: is_payload
   output      logic                           rsp_tuser,
   // rsp_tlast: frame_done
   output      logic                           rsp_tlast,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [sfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sfc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import sfc_pkg::*;

   start_cfg_type cfg_ff;
   result_type    result;
   result_type    out_ff, out_in;
   result_type    skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   logic          req_accept;

   // Start byte registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_FIRST:  cfg_ff.start_first  <= csr_data;
            CSR_START_SECOND: cfg_ff.start_second <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   sfc_core #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .frame_byte  (req_tdata[7:0]),
      .final_byte  (req_tlast),
      .start_cfg   (cfg_ff),
      .result      (result)
   );

   // Output register with a skid register behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_valid_in  = skid_valid_ff || req_accept;
         out_in        = skid_valid_ff ? skid_ff : result;
         skid_valid_in = 1'b0;
      end else if (req_accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Result word packing.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.is_payload;
   assign rsp_tlast  = out_ff.frame_done;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0),
                        out_ff.crc_computed, out_ff.crc_received, out_ff.length_res,
                        out_ff.sequence_res, out_ff.msg_type, out_ff.version,
                        out_ff.status, out_ff.payload_index, out_ff.payload_byte};

endmodule
`default_nettype wire

### design/sfc_checker.sv
// Port-level assertions for the sensor frame checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_frame_checker_macros.svh"
module sfc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [sfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tuser,
   input wire logic                           rsp_tlast
);
   import sfc_pkg::*;

   logic                  rsp_stall;
   logic [RSP_DATA_W+1:0] rsp_word;

   // The whole result word as it shows on the ports, and whether it is held back.
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tdata, rsp_tuser, rsp_tlast};

   // A stalled result word holds.
   `SFC_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_stall, ##1 (rsp_tvalid && $stable(rsp_word)))

   // Payload position and byte read as zero outside the payload.
   `SFC_ASSERT_IMPL(a_no_payload_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[23:0] == 24'd0)

   // Summary fields read as zero except on the final byte of a frame.
   `SFC_ASSERT_IMPL(a_summary_zero, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[RSP_DATA_W-1:24] == '0)

   // An accepted word is always followed by a valid result word on the next cycle.
   `SFC_ASSERT_IMPL(a_accept_result, clock, reset, req_tvalid && req_tready, ##1 rsp_tvalid)

   // Reset empties the result buffer.
   `SFC_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind sensor_frame_checker sfc_checker u_sfc_checker (.*);
`default_nettype wire
